FILE: sv/pstf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstf_pkg: shared types and constants of the piece span mapper
// widths of the word fields, status codes, command and result structs
// ----------------------------------------------------------------------------
package pstf_pkg;

   localparam int SLOT_W  = 6;
   localparam int LEN_W   = 40;
   localparam int PIDX_W  = 20;
   localparam int POFF_W  = 24;
   localparam int REQ_W   = 25;
   localparam int PSIZE_W = 25;
   localparam int FCNT_W  = 7;
   localparam int PROD_W  = PIDX_W + PSIZE_W;
   // absolute position plus span, and the running total of 64 files
   localparam int POS_W   = 47;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QPTR_W      = 1;
   localparam int QUEUE_DEPTH = 2 ** QPTR_W;

   localparam logic [PSIZE_W-1:0] PIECE_SIZE_RST = 25'd262144;
   localparam logic [FCNT_W-1:0]  FILE_COUNT_RST = 7'd1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_MAP  = 1'b1;

   // register index, taken from the word address bit
   localparam logic REG_PIECE_SIZE = 1'b0;
   localparam logic REG_FILE_COUNT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_SEG    = 2'd0,
      STATUS_ACK    = 2'd1,
      STATUS_BEYOND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK,
      BK_CHECK,
      BK_EMIT_RD,
      BK_EMIT_OUT
   } back_state_type;

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  length;
      logic [POS_W-1:0]  pos;
      logic [REQ_W-1:0]  req;
   } cmd_type;

   typedef struct packed {
      logic [PSIZE_W-1:0] piece_size;
      logic [FCNT_W-1:0]  file_count;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0] file_index;
      logic [LEN_W-1:0]  file_offset;
      logic [REQ_W-1:0]  length;
      logic              last;
      status_type        status;
   } rsp_type;

endpackage
`default_nettype wire

FILE: sv/pstf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstf_ram: generic single write port, single read port ram
// read data is registered behind the read address
// ----------------------------------------------------------------------------
module pstf_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [AW-1:0]        raddr,
   output      logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: sv/pstf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstf_front: input stage of the piece span mapper
// registers an input word and forms the absolute position for the queue
// ----------------------------------------------------------------------------
module pstf_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_func,
   input  wire logic [pstf_pkg::SLOT_W-1:0]    req_file_slot,
   input  wire logic [pstf_pkg::LEN_W-1:0]     req_file_length,
   input  wire logic [pstf_pkg::PIDX_W-1:0]    req_piece_index,
   input  wire logic [pstf_pkg::POFF_W-1:0]    req_piece_offset,
   input  wire logic [pstf_pkg::REQ_W-1:0]     req_request_length,
   input  wire logic [pstf_pkg::PSIZE_W-1:0]   piece_size,
   output      logic                           push_valid,
   input  wire logic                           push_ready,
   output      pstf_pkg::cmd_type              push_cmd
);

   logic                          s_valid_ff, s_valid_in;
   logic                          func_ff;
   logic [pstf_pkg::SLOT_W-1:0]   slot_ff;
   logic [pstf_pkg::LEN_W-1:0]    length_ff;
   logic [pstf_pkg::PIDX_W-1:0]   pidx_ff;
   logic [pstf_pkg::POFF_W-1:0]   poff_ff;
   logic [pstf_pkg::REQ_W-1:0]    reqlen_ff;
   logic [pstf_pkg::PROD_W-1:0]   prod;

   assign req_ready = !s_valid_ff || push_ready;

   always_comb begin
      s_valid_in = s_valid_ff;
      if (req_ready) begin
         s_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff   <= req_func;
         slot_ff   <= req_file_slot;
         length_ff <= req_file_length;
         pidx_ff   <= req_piece_index;
         poff_ff   <= req_piece_offset;
         reqlen_ff <= req_request_length;
      end
   end

   // one multiply and one add ahead of the queue
   assign prod = pstf_pkg::PROD_W'(pidx_ff) * pstf_pkg::PROD_W'(piece_size);

   always_comb begin
      push_cmd.func   = func_ff;
      push_cmd.slot   = slot_ff;
      push_cmd.length = length_ff;
      push_cmd.pos    = pstf_pkg::POS_W'(prod) + pstf_pkg::POS_W'(poff_ff);
      push_cmd.req    = reqlen_ff;
   end

   assign push_valid = s_valid_ff;

endmodule
`default_nettype wire

FILE: sv/pstf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstf_queue: short command queue between front and back
// lets the input side and the table walker stall independently
// ----------------------------------------------------------------------------
module pstf_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output      logic                 push_ready,
   input  wire pstf_pkg::cmd_type    push_cmd,
   output      logic                 pop_valid,
   input  wire logic                 pop,
   output      pstf_pkg::cmd_type    pop_cmd
);

   pstf_pkg::cmd_type                 entry_ff [pstf_pkg::QUEUE_DEPTH];
   logic [pstf_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pstf_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pstf_pkg::QPTR_W:0]         count_ff, count_in;
   logic                              do_push, do_pop;

   assign push_ready = count_ff != (pstf_pkg::QPTR_W + 1)'(pstf_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: sv/pstf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstf_back: table walker and segment emitter
// holds the file length table, walks it once to find the start file and
// the total, then reads it again to emit one segment per file touched
// ----------------------------------------------------------------------------
module pstf_back #(
   parameter int MAX_FILES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire pstf_pkg::cmd_type    q_cmd,
   output      logic                 q_pop,
   input  wire pstf_pkg::cfg_type    cfg,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      pstf_pkg::rsp_type    rsp
);

   localparam int IDX_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int CNT_W = $clog2(MAX_FILES + 1);

   pstf_pkg::back_state_type          state_ff, state_in;
   logic [pstf_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [pstf_pkg::POS_W-1:0]        cum_ff, cum_in;
   logic [pstf_pkg::REQ_W-1:0]        rem_ff, rem_in;
   logic                              found_ff, found_in;
   logic [IDX_W-1:0]                  cur_idx_ff, cur_idx_in;
   logic [pstf_pkg::LEN_W-1:0]        off_ff, off_in;
   logic [CNT_W-1:0]                  issue_ff, issue_in;
   logic                              rvalid_ff, rvalid_in;
   logic [IDX_W-1:0]                  ridx_ff, ridx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pstf_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                              ram_we;
   logic [IDX_W-1:0]                  ram_waddr, ram_raddr;
   logic [pstf_pkg::LEN_W-1:0]        ram_rdata;

   logic [pstf_pkg::FCNT_W-1:0]       count_lim;
   logic [CNT_W-1:0]                  n;
   logic                              out_free;
   logic [pstf_pkg::POS_W-1:0]        cum_next, fit_end;
   logic [pstf_pkg::LEN_W-1:0]        room;
   logic [pstf_pkg::REQ_W-1:0]        take, rem_left;
   logic                              issuing;

   function automatic pstf_pkg::rsp_type make_rsp(
      input logic [IDX_W-1:0]           idx,
      input logic [pstf_pkg::LEN_W-1:0] off,
      input logic [pstf_pkg::REQ_W-1:0] len,
      input logic                       last,
      input pstf_pkg::status_type       status
   );
      pstf_pkg::rsp_type r;
      r.file_index  = pstf_pkg::SLOT_W'(idx);
      r.file_offset = off;
      r.length      = len;
      r.last        = last;
      r.status      = status;
      return r;
   endfunction

   pstf_ram #(
      .WIDTH (pstf_pkg::LEN_W),
      .DEPTH (MAX_FILES)
   ) u_pstf_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (q_cmd.length),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign count_lim = (cfg.file_count > pstf_pkg::FCNT_W'(MAX_FILES)) ?
                      pstf_pkg::FCNT_W'(MAX_FILES) : cfg.file_count;
   assign n         = CNT_W'(count_lim);

   assign ram_waddr = q_cmd.slot[IDX_W-1:0];
   assign ram_raddr = (state_ff == pstf_pkg::BK_WALK) ? issue_ff[IDX_W-1:0] : cur_idx_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cum_next  = cum_ff + pstf_pkg::POS_W'(ram_rdata);
   assign fit_end   = pos_ff + pstf_pkg::POS_W'(rem_ff);
   assign room      = ram_rdata - off_ff;
   assign take      = (pstf_pkg::LEN_W'(rem_ff) < room) ? rem_ff : pstf_pkg::REQ_W'(room);
   assign rem_left  = rem_ff - take;
   assign issuing   = issue_ff < n;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cum_in       = cum_ff;
      rem_in       = rem_ff;
      found_in     = found_ff;
      cur_idx_in   = cur_idx_ff;
      off_in       = off_ff;
      issue_in     = issue_ff;
      rvalid_in    = 1'b0;
      ridx_in      = ridx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;

      case (state_ff)
         pstf_pkg::BK_IDLE: begin
            if (q_valid) begin
               if (q_cmd.func == pstf_pkg::FUNC_LOAD) begin
                  if (out_free) begin
                     // slots past the table are dropped but still acknowledged
                     ram_we       = (pstf_pkg::FCNT_W'(q_cmd.slot) <
                                     pstf_pkg::FCNT_W'(MAX_FILES));
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp('0, '0, '0, 1'b1, pstf_pkg::STATUS_ACK);
                  end
               end else if (n == '0) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp('0, '0, '0, 1'b1, pstf_pkg::STATUS_BEYOND);
                  end
               end else begin
                  q_pop    = 1'b1;
                  pos_in   = q_cmd.pos;
                  rem_in   = q_cmd.req;
                  cum_in   = '0;
                  found_in = 1'b0;
                  issue_in = '0;
                  state_in = pstf_pkg::BK_WALK;
               end
            end
         end

         pstf_pkg::BK_WALK: begin
            // one table read issued and one checked per cycle
            if (issuing) begin
               issue_in = issue_ff + 1'b1;
            end
            rvalid_in = issuing;
            ridx_in   = issue_ff[IDX_W-1:0];
            if (rvalid_ff) begin
               cum_in = cum_next;
               if (!found_ff && (cum_next > pos_ff)) begin
                  found_in   = 1'b1;
                  cur_idx_in = ridx_ff;
                  off_in     = pstf_pkg::LEN_W'(pos_ff - cum_ff);
               end
               if (CNT_W'(ridx_ff) == (n - 1'b1)) begin
                  rvalid_in = 1'b0;
                  state_in  = pstf_pkg::BK_CHECK;
               end
            end
         end

         pstf_pkg::BK_CHECK: begin
            if (!found_ff || (fit_end > cum_ff)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp('0, '0, '0, 1'b1, pstf_pkg::STATUS_BEYOND);
                  state_in     = pstf_pkg::BK_IDLE;
               end
            end else if (rem_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(cur_idx_ff, off_ff, '0, 1'b1,
                                          pstf_pkg::STATUS_SEG);
                  state_in     = pstf_pkg::BK_IDLE;
               end
            end else begin
               state_in = pstf_pkg::BK_EMIT_RD;
            end
         end

         pstf_pkg::BK_EMIT_RD: begin
            state_in = pstf_pkg::BK_EMIT_OUT;
         end

         pstf_pkg::BK_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(cur_idx_ff, off_ff, take, rem_left == '0,
                                       pstf_pkg::STATUS_SEG);
               rem_in       = rem_left;
               off_in       = '0;
               cur_idx_in   = cur_idx_ff + 1'b1;
               state_in     = (rem_left == '0) ? pstf_pkg::BK_IDLE : pstf_pkg::BK_EMIT_RD;
            end
         end

         default: begin
            state_in = pstf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pstf_pkg::BK_IDLE;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         issue_ff     <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cum_ff     <= cum_in;
      rem_ff     <= rem_in;
      cur_idx_ff <= cur_idx_in;
      off_ff     <= off_in;
      ridx_ff    <= ridx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/piece_span_to_file_segments.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piece_span_to_file_segments: piece span to file segment mapper
// keeps a file length table and splits piece spans into per-file segments
// ----------------------------------------------------------------------------
//   channel   direction   handshake                   carries
//   req_      in          req_valid / req_ready       load or map word
//   rsp_      out         rsp_valid / rsp_ready       segment, ack or error
//   csr_      in/out      csr_psel / csr_penable      piece_size, file_count
//
// a word passes the input stage register and the queue before the walker
// a load word, or a map word with file_count 0, is answered by the walker in
// its idle state, through the result register
// a map word is popped, walked with one registered ram read for each of the
// file_count files (capped at MAX_FILES), checked, and then emits each
// segment through a ram read state and an output state
// a two-word queue sits between input stage and walker; the result register
// lets the walker continue while a word waits on rsp_ready
// synchronous reset; the file table itself is not cleared
// ----------------------------------------------------------------------------
module piece_span_to_file_segments #(
   parameter int MAX_FILES = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire logic                                  req_func,
   input  wire logic [pstf_pkg::SLOT_W-1:0]           req_file_slot,
   input  wire logic [pstf_pkg::LEN_W-1:0]            req_file_length,
   input  wire logic [pstf_pkg::PIDX_W-1:0]           req_piece_index,
   input  wire logic [pstf_pkg::POFF_W-1:0]           req_piece_offset,
   input  wire logic [pstf_pkg::REQ_W-1:0]            req_request_length,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic [pstf_pkg::SLOT_W-1:0]           rsp_seg_file_index,
   output      logic [pstf_pkg::LEN_W-1:0]            rsp_seg_file_offset,
   output      logic [pstf_pkg::REQ_W-1:0]            rsp_seg_length,
   output      logic                                  rsp_last,
   output      logic [1:0]                            rsp_status,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [pstf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire logic [pstf_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output      logic [pstf_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output      logic                                  csr_pready
);

   logic [pstf_pkg::PSIZE_W-1:0]   piece_size_ff, piece_size_in;
   logic [pstf_pkg::FCNT_W-1:0]    file_count_ff, file_count_in;
   logic                           csr_wr;
   logic                           reg_sel;
   pstf_pkg::cfg_type              cfg;

   logic                           push_valid, push_ready;
   pstf_pkg::cmd_type              push_cmd;
   logic                           q_valid, q_pop;
   pstf_pkg::cmd_type              q_cmd;
   pstf_pkg::rsp_type              rsp;

   // register index is the word address
   assign reg_sel    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      piece_size_in = piece_size_ff;
      file_count_in = file_count_ff;
      if (csr_wr) begin
         case (reg_sel)
            pstf_pkg::REG_PIECE_SIZE: piece_size_in = csr_pwdata[pstf_pkg::PSIZE_W-1:0];
            pstf_pkg::REG_FILE_COUNT: file_count_in = csr_pwdata[pstf_pkg::FCNT_W-1:0];
            default: begin
               piece_size_in = piece_size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_size_ff <= pstf_pkg::PIECE_SIZE_RST;
         file_count_ff <= pstf_pkg::FILE_COUNT_RST;
      end else begin
         piece_size_ff <= piece_size_in;
         file_count_ff <= file_count_in;
      end
   end

   assign csr_prdata = (reg_sel == pstf_pkg::REG_PIECE_SIZE) ?
                       pstf_pkg::CSR_DATA_W'(piece_size_ff) :
                       pstf_pkg::CSR_DATA_W'(file_count_ff);

   assign cfg.piece_size = piece_size_ff;
   assign cfg.file_count = file_count_ff;

   pstf_front u_pstf_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_file_slot      (req_file_slot),
      .req_file_length    (req_file_length),
      .req_piece_index    (req_piece_index),
      .req_piece_offset   (req_piece_offset),
      .req_request_length (req_request_length),
      .piece_size         (cfg.piece_size),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_cmd           (push_cmd)
   );

   pstf_queue u_pstf_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (q_cmd)
   );

   pstf_back #(
      .MAX_FILES (MAX_FILES)
   ) u_pstf_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_seg_file_index  = rsp.file_index;
   assign rsp_seg_file_offset = rsp.file_offset;
   assign rsp_seg_length      = rsp.length;
   assign rsp_last            = rsp.last;
   assign rsp_status          = rsp.status;

endmodule
`default_nettype wire

FILE: sv/pstf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstf_checker: port level checks of the piece span mapper
// result shapes per status, segment chaining and output hold under stall
// ----------------------------------------------------------------------------
module pstf_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [pstf_pkg::SLOT_W-1:0]           rsp_seg_file_index,
   input wire logic [pstf_pkg::LEN_W-1:0]            rsp_seg_file_offset,
   input wire logic [pstf_pkg::REQ_W-1:0]            rsp_seg_length,
   input wire logic                                  rsp_last,
   input wire logic [1:0]                            rsp_status
);

   // acknowledge is a single empty word
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pstf_pkg::STATUS_ACK) |->
         rsp_last && (rsp_seg_length == '0) && (rsp_seg_file_offset == '0) &&
         (rsp_seg_file_index == '0))
      else $error("load acknowledge is not a single empty word");

   a_beyond_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pstf_pkg::STATUS_BEYOND) |->
         rsp_last && (rsp_seg_length == '0) && (rsp_seg_file_offset == '0))
      else $error("span error is not a single empty word");

   a_only_segments_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_status == pstf_pkg::STATUS_SEG))
      else $error("non-final word is not a segment");

   // the word after a non-final segment starts the next file at offset zero
   a_chain_next_file: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         !rsp_valid ||
         ((rsp_seg_file_offset == '0) &&
          (rsp_seg_file_index == $past(rsp_seg_file_index) + 1'b1)))
      else $error("segment chain broken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_seg_file_index) && $stable(rsp_seg_file_offset) &&
         $stable(rsp_seg_length) && $stable(rsp_last) && $stable(rsp_status))
      else $error("result word changed while stalled");

endmodule

bind piece_span_to_file_segments pstf_checker u_pstf_checker (.*);
`default_nettype wire

FILE: bench/pstf_segment_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstf_segment_checker: result checker for the piece span mapper
// follows the word, result and register ports, predicts the segments that
// every accepted word should produce and compares them in order with the
// results that the block hands out; register reads are checked as well
// ----------------------------------------------------------------------------
module pstf_segment_checker #(
   parameter int MAX_FILES = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic                              req_func,
   input  wire logic [pstf_pkg::SLOT_W-1:0]       req_file_slot,
   input  wire logic [pstf_pkg::LEN_W-1:0]        req_file_length,
   input  wire logic [pstf_pkg::PIDX_W-1:0]       req_piece_index,
   input  wire logic [pstf_pkg::POFF_W-1:0]       req_piece_offset,
   input  wire logic [pstf_pkg::REQ_W-1:0]        req_request_length,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [pstf_pkg::SLOT_W-1:0]       rsp_seg_file_index,
   input  wire logic [pstf_pkg::LEN_W-1:0]        rsp_seg_file_offset,
   input  wire logic [pstf_pkg::REQ_W-1:0]        rsp_seg_length,
   input  wire logic                              rsp_last,
   input  wire logic [1:0]                        rsp_status,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pstf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pstf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  wire logic [pstf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  wire logic                              csr_pready,
   output int                                     mismatch_count,
   output int                                     outstanding
);
   import pstf_pkg::*;

   logic [LEN_W-1:0]      length_table [MAX_FILES];
   logic [PSIZE_W-1:0]    piece_size_q;
   logic [FCNT_W-1:0]     file_count_q;
   rsp_type               pending_segments [$];
   rsp_type               want;
   logic [CSR_DATA_W-1:0] reg_value;

   assign outstanding = pending_segments.size();

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] exp_value);
      if (got !== exp_value)
         report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, exp_value));
   endtask

   task automatic push_segment(input logic [SLOT_W-1:0] idx, input logic [LEN_W-1:0] off,
                               input logic [REQ_W-1:0] len, input logic last,
                               input status_type status);
      rsp_type r;
      r.file_index  = idx;
      r.file_offset = off;
      r.length      = len;
      r.last        = last;
      r.status      = status;
      pending_segments.push_back(r);
   endtask

   // table update for a load word, segment split for a map word
   task automatic map_word_to_segments(input logic func, input logic [SLOT_W-1:0] slot,
                                       input logic [LEN_W-1:0] flen,
                                       input logic [PIDX_W-1:0] pidx,
                                       input logic [POFF_W-1:0] poff,
                                       input logic [REQ_W-1:0] rlen);
      logic [63:0] pos, need, room, avail, take;
      int          limit, idx, j;
      if (func == FUNC_LOAD) begin
         if (int'(slot) < MAX_FILES) length_table[slot] = flen;
         push_segment('0, '0, '0, 1'b1, STATUS_ACK);
         return;
      end
      limit = (int'(file_count_q) > MAX_FILES) ? MAX_FILES : int'(file_count_q);
      pos   = 64'(pidx) * 64'(piece_size_q) + 64'(poff);
      need  = 64'(rlen);
      idx   = 0;
      while (idx < limit && 64'(length_table[idx]) <= pos) begin
         pos -= 64'(length_table[idx]);
         idx++;
      end
      // bytes from the start of the start file to the end of the last valid file
      avail = 0;
      for (j = idx; j < limit; j++) avail += 64'(length_table[j]);
      if (idx >= limit || avail - pos < need) begin
         push_segment('0, '0, '0, 1'b1, STATUS_BEYOND);
         return;
      end
      if (need == 0) begin
         push_segment(SLOT_W'(idx), pos[LEN_W-1:0], '0, 1'b1, STATUS_SEG);
         return;
      end
      while (need != 0) begin
         room = 64'(length_table[idx]) - pos;
         take = (need < room) ? need : room;
         need -= take;
         push_segment(SLOT_W'(idx), pos[LEN_W-1:0], take[REQ_W-1:0], need == 0, STATUS_SEG);
         idx++;
         pos = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         piece_size_q = PIECE_SIZE_RST;
         file_count_q = FILE_COUNT_RST;
         foreach (length_table[i]) length_table[i] = '0;
         pending_segments.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[CSR_ADDR_W-1] == REG_PIECE_SIZE)
                  piece_size_q = csr_pwdata[PSIZE_W-1:0];
               else
                  file_count_q = csr_pwdata[FCNT_W-1:0];
            end else begin
               reg_value = (csr_paddr[CSR_ADDR_W-1] == REG_PIECE_SIZE) ?
                           CSR_DATA_W'(piece_size_q) : CSR_DATA_W'(file_count_q);
               compare_field($sformatf("register read at %0d", csr_paddr),
                             64'(csr_prdata), 64'(reg_value));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_segments.size() == 0) begin
               report_mismatch($sformatf(
                  "unexpected result: file %0d offset %0d length %0d status %0d",
                  rsp_seg_file_index, rsp_seg_file_offset, rsp_seg_length, rsp_status));
            end else begin
               want = pending_segments.pop_front();
               compare_field("file index", 64'(rsp_seg_file_index), 64'(want.file_index));
               compare_field("file offset", 64'(rsp_seg_file_offset), 64'(want.file_offset));
               compare_field("segment length", 64'(rsp_seg_length), 64'(want.length));
               compare_field("last", 64'(rsp_last), 64'(want.last));
               compare_field("status", 64'(rsp_status), 64'(want.status));
            end
         end
         if (req_valid && req_ready)
            map_word_to_segments(req_func, req_file_slot, req_file_length, req_piece_index,
                                 req_piece_offset, req_request_length);
      end
   end

endmodule

FILE: bench/tb_piece_span_to_file_segments.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piece_span_to_file_segments: testbench of the piece span mapper
// loads file length tables, maps directed and random piece spans across
// several piece size and file count settings with random gaps and result
// stalls; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_piece_span_to_file_segments;
   import pstf_pkg::*;

   localparam int              MAX_FILES       = 64;
   localparam int              STALL_LIMIT     = 2000;
   localparam int              SETTLE_CYCLES   = 200;
   localparam longint unsigned REQ_HIGH        = 64'd16777216;
   localparam longint unsigned REQ_ALL         = 64'h1FF_FFFF;
   localparam longint unsigned POFF_ALL        = 64'hFF_FFFF;
   localparam longint unsigned PIDX_ALL        = 64'hF_FFFF;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PIECE_SIZE = {REG_PIECE_SIZE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_FILE_COUNT = {REG_FILE_COUNT, 2'b00};

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic                  req_func           = FUNC_LOAD;
   logic [SLOT_W-1:0]     req_file_slot      = '0;
   logic [LEN_W-1:0]      req_file_length    = '0;
   logic [PIDX_W-1:0]     req_piece_index    = '0;
   logic [POFF_W-1:0]     req_piece_offset   = '0;
   logic [REQ_W-1:0]      req_request_length = '0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [SLOT_W-1:0]     rsp_seg_file_index;
   logic [LEN_W-1:0]      rsp_seg_file_offset;
   logic [REQ_W-1:0]      rsp_seg_length;
   logic                  rsp_last;
   logic [1:0]            rsp_status;
   logic                  csr_psel           = 1'b0;
   logic                  csr_penable        = 1'b0;
   logic                  csr_pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr          = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata         = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int              mismatch_count;
   int              outstanding;
   bit              idling       = 1'b1;
   int              stall_left   = 0;
   int              quiet_cycles = 0;
   longint unsigned planned_lengths [MAX_FILES];

   piece_span_to_file_segments #(.MAX_FILES(MAX_FILES)) uut (.*);

   pstf_segment_checker #(.MAX_FILES(MAX_FILES)) u_segment_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure in random bursts while idling is set
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic longint unsigned rand_below(input longint unsigned bound);
      return {$urandom, $urandom} % bound;
   endfunction

   function automatic longint unsigned pick_length(input longint unsigned scale,
                                                   input int zero_pct);
      if ($urandom_range(0, 99) < zero_pct) return 0;
      return rand_below(scale);
   endfunction

   task automatic send_word(input logic func, input longint unsigned slot, flen, pidx, poff,
                            rlen);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= func;
      req_file_slot      <= slot[SLOT_W-1:0];
      req_file_length    <= flen[LEN_W-1:0];
      req_piece_index    <= pidx[PIDX_W-1:0];
      req_piece_offset   <= poff[POFF_W-1:0];
      req_request_length <= rlen[REQ_W-1:0];
      do @(posedge clock); while (!req_ready);
   endtask

   // unused fields of a word carry random junk
   task automatic load_file(input int slot, input longint unsigned flen);
      planned_lengths[slot] = flen;
      send_word(FUNC_LOAD, slot, flen, $urandom, $urandom, $urandom);
   endtask

   task automatic map_span(input longint unsigned pidx, poff, rlen);
      send_word(FUNC_MAP, $urandom, {$urandom, $urandom}, pidx, poff, rlen);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input longint unsigned data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input longint unsigned psize, input int fcount);
      wait_idle();
      csr_access(1'b1, ADDR_PIECE_SIZE, psize);
      csr_access(1'b1, ADDR_FILE_COUNT, fcount);
      csr_access(1'b0, ADDR_PIECE_SIZE, 0);
      csr_access(1'b0, ADDR_FILE_COUNT, 0);
   endtask

   task automatic random_phase(input longint unsigned psize, input int fcount,
                               input longint unsigned scale, input int zero_pct,
                               input int items, input bit idle);
      longint unsigned total, target, remaining, max_pos, pidx, poff, rlen;
      int              n, s, b, roll;
      set_config(psize, fcount);
      idling = idle;
      n = (fcount > MAX_FILES) ? MAX_FILES : fcount;
      for (s = 0; s < n; s++) load_file(s, pick_length(scale, zero_pct));
      repeat (items) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            load_file($urandom_range(0, MAX_FILES - 1), pick_length(scale, zero_pct));
         end else if (roll < 18) begin
            map_span($urandom, $urandom, $urandom);
         end else begin
            total = 0;
            for (s = 0; s < n; s++) total += planned_lengths[s];
            // start on a file boundary now and then, else anywhere up to a bit past the end
            if ($urandom_range(0, 3) == 0) begin
               target = 0;
               b      = $urandom_range(0, n - 1);
               for (s = 0; s < b; s++) target += planned_lengths[s];
            end else begin
               target = rand_below(total + total / 8 + 1);
            end
            if (psize == 0)
               max_pos = POFF_ALL;
            else
               max_pos = PIDX_ALL * psize + ((psize - 1 < POFF_ALL) ? psize - 1 : POFF_ALL);
            if (target > max_pos) target = max_pos;
            if (psize == 0) begin
               pidx = $urandom;
               poff = target;
            end else begin
               pidx = target / psize;
               poff = target % psize;
               // offset reaching past the end of its piece
               if (pidx != 0 && poff + psize <= POFF_ALL && $urandom_range(0, 1) == 0) begin
                  pidx--;
                  poff += psize;
               end
            end
            remaining = (total > target) ? total - target : 0;
            case ($urandom_range(0, 9))
               0:       rlen = 0;
               1:       rlen = remaining + 1;
               2:       rlen = remaining;
               default: rlen = rand_below(((remaining < REQ_HIGH) ? remaining : REQ_HIGH) + 1);
            endcase
            if (rlen > REQ_ALL) rlen = REQ_ALL;
            map_span(pidx, poff, rlen);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, ADDR_PIECE_SIZE, 0);
      csr_access(1'b0, ADDR_FILE_COUNT, 0);

      // reset settings, one huge file
      load_file(0, 64'hFF_FFFF_FFFF);
      map_span(0, 0, 0);
      map_span(PIDX_ALL, POFF_ALL, REQ_HIGH);
      map_span(5, 7, 1);

      // zero piece size; empty files before, inside and after the span
      set_config(0, 5);
      load_file(0, 0);
      load_file(1, 10);
      load_file(2, 0);
      load_file(3, 5);
      load_file(4, 0);
      map_span(PIDX_ALL, 0, 15);
      map_span(0, 10, 0);
      map_span(0, 15, 0);
      map_span(0, 3, 13);
      map_span(123, 3, 12);
      map_span(0, 14, 1);

      // no valid files at all
      set_config(1, 0);
      map_span(0, 0, 0);
      load_file(MAX_FILES - 1, 64'hAA_AAAA_AAAA);

      set_config(REQ_HIGH, 2);
      map_span(0, 9, 1);
      map_span(1, 0, 0);

      random_phase(262144, 8, 64'd1 << 20, 10, 35, $urandom_range(0, 3) != 0);
      random_phase(1, 16, 64, 25, 35, $urandom_range(0, 3) != 0);
      random_phase(0, 12, 4096, 10, 30, $urandom_range(0, 3) != 0);
      random_phase(REQ_HIGH, 40, 64'd1 << 22, 10, 40, $urandom_range(0, 3) != 0);
      random_phase(REQ_ALL, 127, 64'd1 << 40, 5, 25, $urandom_range(0, 3) != 0);
      random_phase(1000, 64, 16, 40, 40, $urandom_range(0, 3) != 0);
      random_phase(3, 1, 100, 0, 20, $urandom_range(0, 3) != 0);
      random_phase(4096, 32, 256, 15, 40, 1'b0);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: piece_span_to_file_segments.f
sv/pstf_pkg.sv
sv/pstf_ram.sv
sv/pstf_front.sv
sv/pstf_queue.sv
sv/pstf_back.sv
sv/piece_span_to_file_segments.sv
sv/pstf_checker.sv
bench/pstf_segment_checker.sv
bench/tb_piece_span_to_file_segments.sv
